// File: design/dsha_pkg.sv
// shared types, round constants and helper functions for the double sha-256 header check
// no dependencies; compiled first
package dsha_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] state_t;  // index 0 is a, 7 is h
  typedef logic [15:0][31:0] sched_t; // sliding message window, index 0 is current word

  // one word travelling down the chain of round cells
  typedef struct packed {
    logic   valid;
    state_t state;
    state_t base;
    sched_t sched;
    word_t  nonce;
  } link_t;

  localparam int unsigned NumRounds = 64;

  localparam word_t KRound [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t KInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t PadWord = 32'h8000_0000;
  localparam word_t HeaderTailBits = 32'd640;
  localparam word_t DigestBits = 32'd256;

  localparam logic [31:0] VersionReset = 32'd4;
  localparam logic [31:0] TimeReset    = 32'd1762086000;
  localparam logic [31:0] BitsReset    = 32'h1e0f_fff0;
  localparam logic [23:0] MantMask     = 24'hFF_FFFF;

  // register indexes of the configuration port
  localparam logic [2:0] RegVersion = 3'd0;
  localparam logic [2:0] RegTime    = 3'd1;
  localparam logic [2:0] RegBits    = 3'd2;
  localparam logic [2:0] RegMerkle0 = 3'd3;
  localparam logic [2:0] RegMerkle1 = 3'd4;
  localparam logic [2:0] RegMerkle2 = 3'd5;
  localparam logic [2:0] RegMerkle3 = 3'd6;

  function automatic word_t rotr(word_t x, int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bswap(word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// File: design/dsha_if.sv
// valid/ready channel interfaces for nonce words and result words
// depends on nothing
interface dsha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce;
  modport source (output valid, output nonce, input ready);
  modport sink   (input valid, input nonce, output ready);
endinterface

interface dsha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce_echo;
  logic        meets_target;
  logic        bits_invalid;
  logic [63:0] hash_word_0;
  logic [63:0] hash_word_1;
  logic [63:0] hash_word_2;
  logic [63:0] hash_word_3;
  modport source (output valid, output nonce_echo, output meets_target, output bits_invalid,
                  output hash_word_0, output hash_word_1, output hash_word_2,
                  output hash_word_3, input ready);
  modport sink   (input valid, input nonce_echo, input meets_target, input bits_invalid,
                  input hash_word_0, input hash_word_1, input hash_word_2,
                  input hash_word_3, output ready);
endinterface

// File: design/double_sha256_header_target_check.sv
// Double SHA-256 header check: each nonce word runs through three chains of
// 64 round cells (header block one, header block two, second hash), then one
// register for the digest and one output register with the target compare.
// A new nonce is taken every cycle while the pipeline is not held. The whole
// pipeline advances together and holds only while a finished result waits at
// the output, so the rate is one word per cycle whenever the output side takes
// words. Configuration is read live and must be written only while no nonce is
// in flight.
// depends on dsha_pkg, dsha_if, dsha_compress
module double_sha256_header_target_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  dsha_in_if.sink     in_chan_i,
  dsha_out_if.source  out_chan_o
);
  import dsha_pkg::*;

  logic [31:0] version_q, time_q, bits_q;
  logic [63:0] merkle_q [4];

  logic   en;
  link_t  link0, link1, link2, c1_out, c2_out, c3_out;
  logic   fin_valid_q;
  state_t fin_state_q;
  word_t  fin_nonce_q;
  logic   out_valid_q;
  logic [255:0] hash_d, hash_q;
  logic [255:0] target;
  logic   invalid;
  logic   meets_q, invalid_q;
  word_t  nonce_q;
  logic [255:0] root;
  logic [7:0] hdr [80];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionReset;
      time_q    <= TimeReset;
      bits_q    <= BitsReset;
      for (int i = 0; i < 4; i++) merkle_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVersion: version_q   <= cfg_data_i[31:0];
        RegTime:    time_q      <= cfg_data_i[31:0];
        RegBits:    bits_q      <= cfg_data_i[31:0];
        RegMerkle0: merkle_q[0] <= cfg_data_i;
        RegMerkle1: merkle_q[1] <= cfg_data_i;
        RegMerkle2: merkle_q[2] <= cfg_data_i;
        RegMerkle3: merkle_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // header bytes from the configuration, nonce bytes left out
  assign root = {merkle_q[0], merkle_q[1], merkle_q[2], merkle_q[3]};
  always_comb begin
    for (int i = 0; i < 80; i++) hdr[i] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      hdr[i]      = version_q[8*i +: 8];
      hdr[68 + i] = time_q[8*i +: 8];
      hdr[72 + i] = bits_q[8*i +: 8];
    end
    for (int i = 0; i < 32; i++) hdr[36 + i] = root[8*i +: 8];
  end

  // whole pipeline moves unless a result is stuck at the output
  assign en = !out_valid_q || out_chan_o.ready;
  assign in_chan_i.ready = en;

  // first block enters with the initial hash value
  always_comb begin
    link0.valid = in_chan_i.valid;
    link0.state = KInit;
    link0.base  = KInit;
    link0.nonce = in_chan_i.nonce;
    for (int j = 0; j < 16; j++) begin
      link0.sched[j] = {hdr[4*j], hdr[4*j+1], hdr[4*j+2], hdr[4*j+3]};
    end
  end

  dsha_compress u_blk1 (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .link_i(link0),
                        .link_o(c1_out));

  // second block: header tail, nonce and length padding, from the midstate
  always_comb begin
    link1.valid = c1_out.valid;
    link1.state = c1_out.state;
    link1.base  = c1_out.state;
    link1.nonce = c1_out.nonce;
    link1.sched = '0;
    link1.sched[0]  = {hdr[64], hdr[65], hdr[66], hdr[67]};
    link1.sched[1]  = bswap(time_q);
    link1.sched[2]  = bswap(bits_q);
    link1.sched[3]  = bswap(c1_out.nonce);
    link1.sched[4]  = PadWord;
    link1.sched[15] = HeaderTailBits;
  end

  dsha_compress u_blk2 (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .link_i(link1),
                        .link_o(c2_out));

  // second hash over the 32-byte digest
  always_comb begin
    link2.valid = c2_out.valid;
    link2.state = KInit;
    link2.base  = KInit;
    link2.nonce = c2_out.nonce;
    link2.sched = '0;
    for (int j = 0; j < 8; j++) link2.sched[j] = c2_out.state[j];
    link2.sched[8]  = PadWord;
    link2.sched[15] = DigestBits;
  end

  dsha_compress u_blk3 (.clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .link_i(link2),
                        .link_o(c3_out));

  // digest register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= c3_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_state_q <= c3_out.state;
      fin_nonce_q <= c3_out.nonce;
    end
  end

  // byte-reversed digest as one big-endian number
  always_comb begin
    logic [255:0] dig;
    for (int j = 0; j < 8; j++) dig[255 - 32*j -: 32] = fin_state_q[j];
    for (int i = 0; i < 32; i++) hash_d[255 - 8*i -: 8] = dig[8*i +: 8];
  end

  // compact target expansion
  always_comb begin
    logic [7:0] ex;
    ex      = bits_q[31:24];
    invalid = (ex < 8'd3) || (ex > 8'd32);
    target  = '0;
    if (!invalid) begin
      target = {232'd0, bits_q[23:0] & MantMask} << {ex - 8'd3, 3'b000};
    end
  end

  // output register with compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hash_q    <= hash_d;
      meets_q   <= (hash_d <= target);
      invalid_q <= invalid;
      nonce_q   <= fin_nonce_q;
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.nonce_echo   = nonce_q;
  assign out_chan_o.meets_target = meets_q;
  assign out_chan_o.bits_invalid = invalid_q;
  assign out_chan_o.hash_word_0  = hash_q[255:192];
  assign out_chan_o.hash_word_1  = hash_q[191:128];
  assign out_chan_o.hash_word_2  = hash_q[127:64];
  assign out_chan_o.hash_word_3  = hash_q[63:0];

endmodule

// File: design/dsha_round_cell.sv
// one sha-256 round with its message schedule step, registered
// depends on dsha_pkg
module dsha_round_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  dsha_pkg::link_t link_i,
  output dsha_pkg::link_t link_o
);
  import dsha_pkg::*;

  logic   valid_q;
  state_t state_d, state_q;
  sched_t sched_d, sched_q;
  state_t base_q;
  word_t  nonce_q;

  // compression round and schedule extension
  always_comb begin
    word_t t1, t2, ch, mj, wn;
    state_t v;
    v  = link_i.state;
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + bsig1(v[4]) + ch + KRound[Idx[5:0]] + link_i.sched[0];
    t2 = bsig0(v[0]) + mj;
    state_d[0] = t1 + t2;
    state_d[1] = v[0];
    state_d[2] = v[1];
    state_d[3] = v[2];
    state_d[4] = v[3] + t1;
    state_d[5] = v[4];
    state_d[6] = v[5];
    state_d[7] = v[6];
    wn = link_i.sched[0] + ssig0(link_i.sched[1]) + link_i.sched[9] + ssig1(link_i.sched[14]);
    for (int j = 0; j < 15; j++) begin
      sched_d[j] = link_i.sched[j+1];
    end
    sched_d[15] = wn;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= link_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      sched_q <= sched_d;
      base_q  <= link_i.base;
      nonce_q <= link_i.nonce;
    end
  end

  assign link_o = '{valid: valid_q, state: state_q, base: base_q, sched: sched_q,
                    nonce: nonce_q};

endmodule

// File: design/dsha_compress.sv
// sixty-four round cells in a row plus the feed-forward add of one compression
// depends on dsha_pkg and dsha_round_cell
module dsha_compress (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  dsha_pkg::link_t link_i,
  output dsha_pkg::link_t link_o
);
  import dsha_pkg::*;

  link_t chain [NumRounds+1];

  assign chain[0] = link_i;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    dsha_round_cell #(.Idx(r)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .link_i (chain[r]),
      .link_o (chain[r+1])
    );
  end

  // feed-forward: chaining value plus working state
  always_comb begin
    link_o = chain[NumRounds];
    for (int j = 0; j < 8; j++) begin
      link_o.state[j] = chain[NumRounds].base[j] + chain[NumRounds].state[j];
    end
  end

endmodule
